[rtl/core/bat_pkg.sv]
// Shared types and constants for the advertisement tracker classifier.
// Used by the parser, the top level and the bench; no dependencies.
package bat_pkg;

  // A length byte above this value stops the walk.
  localparam logic [7:0] MAX_FIELD_BYTES = 8'd255;

  localparam logic [7:0]  AD_UUID16_PART  = 8'h02;
  localparam logic [7:0]  AD_UUID16_FULL  = 8'h03;
  localparam logic [7:0]  AD_SERVICE_DATA = 8'h16;
  localparam logic [7:0]  AD_MANUF_DATA   = 8'hFF;

  localparam logic [15:0] CID_OWNER_NET = 16'h004C;
  localparam logic [15:0] CID_TAG_S     = 16'h0075;
  localparam logic [7:0]  SUBTYPE_SEPARATED = 8'h12;

  localparam logic [15:0] UUID_TAG_S_A = 16'hFD5A;
  localparam logic [15:0] UUID_TAG_S_B = 16'hFD59;
  localparam logic [15:0] UUID_TAG_T   = 16'hFEED;
  localparam logic [15:0] UUID_TAG_C   = 16'hFE33;

  // Bit positions in the per-structure hit vector.
  localparam int HIT_OWNER_NET = 0;
  localparam int HIT_S_MANUF   = 1;
  localparam int HIT_S_UUID    = 2;
  localparam int HIT_T         = 3;
  localparam int HIT_C         = 4;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_OWNER_NET = 3'd1,
    KIND_TAG_S     = 3'd2,
    KIND_TAG_T     = 3'd3,
    KIND_TAG_C     = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  separated;
  } result_t;

endpackage

[rtl/core/bat_if.sv]
// Valid/ready channel interfaces for the advertisement tracker classifier.
// No dependencies.
interface bat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] adv_byte;
  logic       last_byte;

  modport source(output valid, adv_byte, last_byte, input ready);
  modport sink(input valid, adv_byte, last_byte, output ready);
endinterface

interface bat_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] tracker_kind;
  logic       separated_flag;

  modport source(output valid, tracker_kind, separated_flag, input ready);
  modport sink(input valid, tracker_kind, separated_flag, output ready);
endinterface

[rtl/core/bat_parser.sv]
// Byte-serial walker over the length/type/data structures of one advertisement.
// Depends on bat_pkg; the result is valid in the cycle the last byte is accepted.
module bat_parser import bat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_acc,
  input  logic [7:0] adv_byte,
  input  logic       last_byte,
  output result_t    result
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  field_type_r, field_type_nxt;
  logic [7:0]  data_offset_r, data_offset_nxt;
  logic [7:0]  data_length_r, data_length_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic [15:0] company_r, company_nxt;
  logic [4:0]  hits_r, hits_nxt;
  kind_t       found_kind_r, found_kind_nxt;
  logic        found_sep_r, found_sep_nxt;
  logic [15:0] word;

  function automatic logic [4:0] uuid_hits(input logic [15:0] w);
    logic [4:0] h;
    h = '0;
    h[HIT_S_UUID] = (w == UUID_TAG_S_A) || (w == UUID_TAG_S_B);
    h[HIT_T]      = (w == UUID_TAG_T);
    h[HIT_C]      = (w == UUID_TAG_C);
    return h;
  endfunction

  function automatic kind_t classify(input logic [4:0] h);
    kind_t k;
    if (h[HIT_OWNER_NET]) begin
      k = KIND_OWNER_NET;
    end else if (h[HIT_S_MANUF] || h[HIT_S_UUID]) begin
      k = KIND_TAG_S;
    end else if (h[HIT_T]) begin
      k = KIND_TAG_T;
    end else if (h[HIT_C]) begin
      k = KIND_TAG_C;
    end else begin
      k = KIND_NONE;
    end
    return k;
  endfunction

  assign word = {adv_byte, low_hold_r};

  // Next-state logic: one byte advances the walk by one step.
  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    field_type_nxt  = field_type_r;
    data_offset_nxt = data_offset_r;
    data_length_nxt = data_length_r;
    low_hold_nxt    = low_hold_r;
    company_nxt     = company_r;
    hits_nxt        = hits_r;
    found_kind_nxt  = found_kind_r;
    found_sep_nxt   = found_sep_r;

    case (phase_r)
      PH_LEN: begin
        if (adv_byte == 8'd0 || adv_byte > MAX_FIELD_BYTES) begin
          phase_nxt = PH_STOP;
        end else begin
          data_length_nxt = adv_byte - 8'd1;
          bytes_left_nxt  = adv_byte - 8'd1;
          data_offset_nxt = '0;
          low_hold_nxt    = '0;
          company_nxt     = '0;
          hits_nxt        = '0;
          phase_nxt       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        field_type_nxt = adv_byte;
        if (bytes_left_r != 8'd0) begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (!data_offset_r[0]) begin
          low_hold_nxt = adv_byte;
        end else if (field_type_r == AD_UUID16_PART || field_type_r == AD_UUID16_FULL) begin
          hits_nxt = hits_r | uuid_hits(word);
        end else if (field_type_r == AD_SERVICE_DATA && data_offset_r == 8'd1) begin
          hits_nxt = hits_r | uuid_hits(word);
        end else if (field_type_r == AD_MANUF_DATA && data_offset_r == 8'd1) begin
          company_nxt = word;
        end
        // The subtype byte follows the two company bytes.
        if (field_type_r == AD_MANUF_DATA && data_offset_r == 8'd2) begin
          if (company_r == CID_OWNER_NET) begin
            if (data_length_r >= 8'd4 && adv_byte == SUBTYPE_SEPARATED) begin
              hits_nxt[HIT_OWNER_NET] = 1'b1;
            end
          end else if (company_r == CID_TAG_S) begin
            hits_nxt[HIT_S_MANUF] = 1'b1;
          end
        end
        data_offset_nxt = data_offset_r + 8'd1;
        if (bytes_left_r != 8'd0) begin
          bytes_left_nxt = bytes_left_r - 8'd1;
        end
      end
      default: begin
      end
    endcase

    // A structure is judged once its final byte has arrived.
    if ((phase_r == PH_TYPE || phase_r == PH_DATA) && bytes_left_nxt == 8'd0) begin
      if (classify(hits_nxt) != KIND_NONE) begin
        found_kind_nxt = classify(hits_nxt);
      end
      if (hits_nxt[HIT_OWNER_NET]) begin
        found_sep_nxt = 1'b1;
      end
      phase_nxt = (found_kind_nxt != KIND_NONE) ? PH_STOP : PH_LEN;
    end
  end

  // Result output: the decision as it stands after this byte.
  always_comb begin
    result.kind      = found_kind_nxt;
    result.separated = found_sep_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_acc && last_byte)) begin
      phase_r       <= PH_LEN;
      bytes_left_r  <= '0;
      field_type_r  <= '0;
      data_offset_r <= '0;
      data_length_r <= '0;
      low_hold_r    <= '0;
      company_r     <= '0;
      hits_r        <= '0;
      found_kind_r  <= KIND_NONE;
      found_sep_r   <= 1'b0;
    end else if (byte_acc) begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      field_type_r  <= field_type_nxt;
      data_offset_r <= data_offset_nxt;
      data_length_r <= data_length_nxt;
      low_hold_r    <= low_hold_nxt;
      company_r     <= company_nxt;
      hits_r        <= hits_nxt;
      found_kind_r  <= found_kind_nxt;
      found_sep_r   <= found_sep_nxt;
    end
  end

endmodule

[rtl/core/ble_adv_tracker_classifier_core.sv]
// Advertisement tracker classifier: one byte per ready cycle, one result per advertisement.
// The result goes to the output register, or to the skid register while the output stalls.
// Throughput: one byte per cycle while ready; parse state updates on each accepted request.
// A skid register lets bytes keep flowing while one result waits for the sink.
// Reset (rst_n low, synchronous) returns the walk to the length byte and empties both
// result registers.
module ble_adv_tracker_classifier_core import bat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bat_in_if.sink    in_chan,
  bat_out_if.source out_chan
);

  result_t res;
  logic    in_acc;
  logic    res_fire;
  logic    out_take;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_res_r, skid_res_nxt;

  assign in_chan.ready = !skid_valid_r;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign res_fire      = in_acc && in_chan.last_byte;
  assign out_take      = out_valid_r && out_chan.ready;

  bat_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (in_acc),
    .adv_byte  (in_chan.adv_byte),
    .last_byte (in_chan.last_byte),
    .result    (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_fire;
        out_res_nxt   = res;
      end
    end else if (res_fire) begin
      // Output is stalled, so park the new result in the skid register.
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.tracker_kind   = out_res_r.kind;
  assign out_chan.separated_flag = out_res_r.separated;

  // The skid register only fills behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output is empty");

  // A last byte accepted with the output free shows up as a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (res_fire && !out_valid_r) |=> out_valid_r)
    else $error("result missing after the last byte");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.kind <= KIND_TAG_C))
    else $error("tracker kind out of range");

  a_sep_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.separated) |-> (out_res_r.kind == KIND_OWNER_NET))
    else $error("separated flag set on a non owner-network result");

endmodule

[sim/testbench.sv]
// Self-checking bench for ble_adv_tracker_classifier_core: drives advertisement bytes,
// predicts each classification result in-line and compares every returned result.
// Depends on bat_pkg and the bat_in_if / bat_out_if channel interfaces.
module testbench import bat_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [7:0] AD_FLAGS = 8'h01;
  localparam int MAX_PRINTED = 40;

  logic clk;
  logic rst_n;

  bat_in_if  in_ch();
  bat_out_if out_ch();

  ble_adv_tracker_classifier_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Parse state of the predictor.
  phase_t      walk_phase;
  logic [7:0]  field_left;
  logic [7:0]  field_kind;
  logic [7:0]  field_offset;
  logic [7:0]  field_len;
  logic [7:0]  low_hold;
  logic [15:0] company;
  logic [4:0]  hits;
  kind_t       found_kind;
  logic        found_sep;

  result_t due_results[$];
  byte_q_t adv_buf;
  byte_q_t field_body;

  int error_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("ble_adv_tracker_classifier_core verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void clear_parse();
    walk_phase = PH_LEN;
    field_left = '0;
    field_kind = '0;
    field_offset = '0;
    field_len = '0;
    low_hold = '0;
    company = '0;
    hits = '0;
    found_kind = KIND_NONE;
    found_sep = 1'b0;
  endfunction

  function automatic void close_structure();
    if (hits[HIT_OWNER_NET]) begin
      found_kind = KIND_OWNER_NET;
      found_sep = 1'b1;
    end else if (hits[HIT_S_MANUF] || hits[HIT_S_UUID]) begin
      found_kind = KIND_TAG_S;
    end else if (hits[HIT_T]) begin
      found_kind = KIND_TAG_T;
    end else if (hits[HIT_C]) begin
      found_kind = KIND_TAG_C;
    end
    walk_phase = (found_kind != KIND_NONE) ? PH_STOP : PH_LEN;
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input logic last);
    logic [15:0] word;
    result_t r;
    case (walk_phase)
      PH_LEN: begin
        if (b == 8'd0 || b > MAX_FIELD_BYTES) begin
          walk_phase = PH_STOP;
        end else begin
          field_len = b - 8'd1;
          field_left = b - 8'd1;
          field_offset = '0;
          low_hold = '0;
          company = '0;
          hits = '0;
          walk_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        field_kind = b;
        if (field_left == 8'd0) close_structure();
        else walk_phase = PH_DATA;
      end
      PH_DATA: begin
        if (!field_offset[0]) begin
          low_hold = b;
        end else begin
          word = {b, low_hold};
          // Lists are searched pair by pair; service data only at its first pair.
          if (field_kind == AD_UUID16_PART || field_kind == AD_UUID16_FULL ||
              (field_kind == AD_SERVICE_DATA && field_offset == 8'd1)) begin
            if (word == UUID_TAG_S_A || word == UUID_TAG_S_B) hits[HIT_S_UUID] = 1'b1;
            if (word == UUID_TAG_T) hits[HIT_T] = 1'b1;
            if (word == UUID_TAG_C) hits[HIT_C] = 1'b1;
          end else if (field_kind == AD_MANUF_DATA && field_offset == 8'd1) begin
            company = word;
          end
        end
        if (field_kind == AD_MANUF_DATA && field_offset == 8'd2) begin
          if (company == CID_OWNER_NET) begin
            if (field_len >= 8'd4 && b == SUBTYPE_SEPARATED) hits[HIT_OWNER_NET] = 1'b1;
          end else if (company == CID_TAG_S) begin
            hits[HIT_S_MANUF] = 1'b1;
          end
        end
        field_offset = field_offset + 8'd1;
        if (field_left != 8'd0) field_left = field_left - 8'd1;
        if (field_left == 8'd0) close_structure();
      end
      default: ;
    endcase
    if (last) begin
      r.kind = found_kind;
      r.separated = found_sep;
      due_results.push_back(r);
      clear_parse();
    end
  endfunction

  // Prediction runs before the compare so that both see one consistent edge.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) classify_byte(in_ch.adv_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d sep=%0b",
                                    out_ch.tracker_kind, out_ch.separated_flag));
        end else begin
          want = due_results.pop_front();
          if (out_ch.tracker_kind !== want.kind)
            report_mismatch($sformatf("tracker_kind %0d, expected %0d",
                                      out_ch.tracker_kind, want.kind));
          if (out_ch.separated_flag !== want.separated)
            report_mismatch($sformatf("separated_flag %0b, expected %0b",
                                      out_ch.separated_flag, want.separated));
        end
      end
    end
  end

  // Result sink: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.adv_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_adv(input byte_q_t bytes);
    for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Sender goes quiet until every predicted result has been returned.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic void push_word(input logic [15:0] w);
    field_body.push_back(w[7:0]);
    field_body.push_back(w[15:8]);
  endfunction

  function automatic logic [15:0] pick_uuid();
    case ($urandom_range(4))
      0: return UUID_TAG_S_A;
      1: return UUID_TAG_S_B;
      2: return UUID_TAG_T;
      3: return UUID_TAG_C;
      default: return 16'($urandom);
    endcase
  endfunction

  // Appends one structure; data bytes beyond the prepared body are random.
  function automatic void add_field(input logic [7:0] ad_type, input int data_len);
    adv_buf.push_back(8'(data_len + 1));
    adv_buf.push_back(ad_type);
    for (int i = 0; i < data_len; i++)
      adv_buf.push_back(i < field_body.size() ? field_body[i] : 8'($urandom_range(255)));
    field_body.delete();
  endfunction

  function automatic void add_noise(input int count);
    repeat (count) adv_buf.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void make_random_adv();
    int cut;
    int pairs;
    adv_buf.delete();
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(9))
        0: add_field(AD_FLAGS, 1);
        1: begin
          push_word(CID_OWNER_NET);
          field_body.push_back(($urandom_range(9) < 7) ? SUBTYPE_SEPARATED
                                                       : 8'($urandom_range(255)));
          add_field(AD_MANUF_DATA, $urandom_range(8, 2));
        end
        2: begin
          push_word(CID_TAG_S);
          add_field(AD_MANUF_DATA, $urandom_range(6, 1));
        end
        3: begin
          push_word(16'($urandom));
          add_field(AD_MANUF_DATA, $urandom_range(6));
        end
        4: begin
          pairs = $urandom_range(4);
          repeat (pairs) push_word(($urandom_range(9) < 4) ? pick_uuid() : 16'($urandom));
          add_field($urandom_range(1) ? AD_UUID16_PART : AD_UUID16_FULL,
                    2 * pairs + $urandom_range(1));
        end
        5: begin
          push_word(($urandom_range(9) < 6) ? pick_uuid() : 16'($urandom));
          add_field(AD_SERVICE_DATA, $urandom_range(6));
        end
        6: begin
          push_word(16'($urandom));
          push_word(pick_uuid());
          add_field(AD_SERVICE_DATA, 4);
        end
        7: add_field(8'($urandom_range(255)), ($urandom_range(19) == 0) ?
                     $urandom_range(60, 20) : $urandom_range(10));
        8: begin
          adv_buf.push_back(8'($urandom_range(255)));
          add_noise($urandom_range(6));
        end
        default: begin
          adv_buf.push_back(8'd0);
          add_noise($urandom_range(4));
        end
      endcase
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(adv_buf.size(), 1);
      while (adv_buf.size() > cut) void'(adv_buf.pop_back());
    end
  endfunction

  task automatic test_stop_conditions();
    send_adv('{8'h00});
    send_adv('{8'h00, 8'h03, AD_UUID16_FULL, UUID_TAG_T[7:0], UUID_TAG_T[15:8]});
    send_adv('{8'hFF});
    send_adv('{8'h03, AD_UUID16_FULL});
    // A length of one holds only the type byte and can never match.
    send_adv('{8'h01, AD_MANUF_DATA});
  endtask

  task automatic test_manufacturer_data();
    send_adv('{8'h02, AD_FLAGS, 8'h06, 8'h07, AD_MANUF_DATA, CID_OWNER_NET[7:0],
               CID_OWNER_NET[15:8], SUBTYPE_SEPARATED, 8'h19, 8'h10, 8'hAA});
    send_adv('{8'h05, AD_MANUF_DATA, CID_OWNER_NET[7:0], CID_OWNER_NET[15:8],
               SUBTYPE_SEPARATED, 8'h19});
    send_adv('{8'h04, AD_MANUF_DATA, CID_OWNER_NET[7:0], CID_OWNER_NET[15:8],
               SUBTYPE_SEPARATED});
    send_adv('{8'h05, AD_MANUF_DATA, CID_OWNER_NET[7:0], CID_OWNER_NET[15:8],
               8'h07, 8'h19});
    send_adv('{8'h04, AD_MANUF_DATA, CID_TAG_S[7:0], CID_TAG_S[15:8], 8'h01});
    send_adv('{8'h03, AD_MANUF_DATA, CID_TAG_S[7:0], CID_TAG_S[15:8]});
  endtask

  task automatic test_uuid_lists();
    send_adv('{8'h03, AD_UUID16_FULL, UUID_TAG_S_A[7:0], UUID_TAG_S_A[15:8]});
    send_adv('{8'h05, AD_UUID16_PART, 8'h11, 8'h22, UUID_TAG_S_B[7:0], UUID_TAG_S_B[15:8]});
    send_adv('{8'h03, AD_UUID16_FULL, UUID_TAG_C[7:0], UUID_TAG_C[15:8]});
    send_adv('{8'h06, AD_UUID16_FULL, UUID_TAG_C[7:0], UUID_TAG_C[15:8],
               UUID_TAG_T[7:0], UUID_TAG_T[15:8], 8'h01});
    // The trailing half of a pair must not complete a UUID.
    send_adv('{8'h04, AD_UUID16_PART, UUID_TAG_C[7:0], UUID_TAG_C[15:8],
               UUID_TAG_S_A[7:0]});
    send_adv('{8'h04, AD_UUID16_FULL, 8'h11, 8'h22, 8'h33});
  endtask

  task automatic test_service_data();
    send_adv('{8'h05, AD_SERVICE_DATA, UUID_TAG_T[7:0], UUID_TAG_T[15:8], 8'h01, 8'h02});
    send_adv('{8'h05, AD_SERVICE_DATA, 8'h01, 8'h02, UUID_TAG_C[7:0], UUID_TAG_C[15:8]});
    send_adv('{8'h02, AD_SERVICE_DATA, UUID_TAG_S_A[7:0]});
    send_adv('{8'h03, AD_SERVICE_DATA, UUID_TAG_S_B[7:0], UUID_TAG_S_B[15:8]});
  endtask

  task automatic test_priority_and_truncation();
    send_adv('{8'h03, AD_UUID16_FULL, UUID_TAG_T[7:0], UUID_TAG_T[15:8],
               8'h05, AD_MANUF_DATA, CID_OWNER_NET[7:0], CID_OWNER_NET[15:8],
               SUBTYPE_SEPARATED, 8'h00});
    send_adv('{8'h05, AD_UUID16_FULL, UUID_TAG_T[7:0], UUID_TAG_T[15:8],
               UUID_TAG_S_A[7:0], UUID_TAG_S_A[15:8]});
    send_adv('{8'h07, AD_MANUF_DATA, CID_OWNER_NET[7:0], CID_OWNER_NET[15:8],
               SUBTYPE_SEPARATED, 8'h19, 8'h10});
    send_adv('{8'h03, AD_UUID16_PART, UUID_TAG_C[7:0], UUID_TAG_C[15:8],
               8'h00, 8'hFF, 8'hFF, 8'h80});
  endtask

  // Structures at the largest length byte, complete and cut short.
  task automatic test_longest_fields();
    int pos;
    adv_buf.delete();
    pos = $urandom_range(126);
    for (int i = 0; i < 127; i++) push_word((i == pos) ? UUID_TAG_T : 16'($urandom));
    add_field(AD_UUID16_FULL, 254);
    send_adv(adv_buf);
    adv_buf.delete();
    push_word(CID_OWNER_NET);
    field_body.push_back(SUBTYPE_SEPARATED);
    add_field(AD_MANUF_DATA, 254);
    send_adv(adv_buf);
    adv_buf.delete();
    push_word(UUID_TAG_S_A);
    add_field(AD_SERVICE_DATA, 254);
    repeat ($urandom_range(20, 1)) void'(adv_buf.pop_back());
    send_adv(adv_buf);
    wait_for_results();
  endtask

  // The sink holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    wait_for_results();
    gap_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    repeat (40) begin
      send_adv('{8'h03, AD_UUID16_FULL, UUID_TAG_T[7:0], UUID_TAG_T[15:8]});
      send_adv('{8'h04, AD_MANUF_DATA, CID_TAG_S[7:0], CID_TAG_S[15:8], 8'h02});
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int gaps[4] = '{0, 56, 0, 13};
    int stalls[4] = '{0, 0, 56, 13};
    int sent;
    for (int p = 0; p < 4; p++) begin
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      sent = 0;
      while (sent < 165) begin
        make_random_adv();
        sent += adv_buf.size();
        send_adv(adv_buf);
      end
      wait_for_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.adv_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    clear_parse();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_stop_conditions();
    test_manufacturer_data();
    test_uuid_lists();
    test_service_data();
    test_priority_and_truncation();
    test_longest_fields();
    test_backpressure();
    test_random_traffic();

    wait_for_results();
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
    if (error_count == 0) begin
      $display("ble_adv_tracker_classifier_core verification clean");
    end else begin
      $display("ble_adv_tracker_classifier_core verification failed");
    end
    $finish;
  end

endmodule
